/* rtl/erdf_pkg.sv */
`timescale 1ns / 1ps

package erdf_pkg;

  localparam int TYPE_W  = 5;
  localparam int CODE_W  = 10;
  localparam int VALUE_W = 32;
  localparam int SEC_W   = 32;
  localparam int USEC_W  = 20;
  localparam int WIN_W   = 9;

  localparam logic [TYPE_W-1:0] TYPE_SYNC = 5'd0;
  localparam logic [TYPE_W-1:0] TYPE_KEY  = 5'd1;
  localparam logic [TYPE_W-1:0] TYPE_MISC = 5'd4;

  localparam logic [CODE_W-1:0] CODE_VOL_DOWN = 10'd114;
  localparam logic [CODE_W-1:0] CODE_VOL_UP   = 10'd115;
  localparam logic [CODE_W-1:0] CODE_SCAN     = 10'd4;

  localparam logic [VALUE_W-1:0] VAL_RELEASE = 32'd0;
  localparam logic [VALUE_W-1:0] VAL_PRESS   = 32'd1;
  localparam logic [VALUE_W-1:0] SCAN_UP     = 32'h000c_00e9;
  localparam logic [VALUE_W-1:0] SCAN_DOWN   = 32'h000c_00ea;

  localparam logic [WIN_W-1:0] WINDOW_MIN   = 9'd10;
  localparam logic [WIN_W-1:0] WINDOW_MAX   = 9'd500;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 9'd100;

  // floor(n / 1000) == (n * 1073742) >> 30 for every n below 2^20
  localparam logic [20:0] RECIP_1000  = 21'd1073742;
  localparam int          RECIP_SHIFT = 30;
  localparam logic [12:0] MS_PER_SEC  = 13'd1000;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  ev_type;
    logic [CODE_W-1:0]  ev_code;
    logic [VALUE_W-1:0] ev_value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

endpackage

/* rtl/erdf_front.sv */
`timescale 1ns / 1ps

module erdf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [erdf_pkg::WIN_W-1:0]    cfg_debounce_ms,
  input  logic                          accept,
  input  logic [erdf_pkg::TYPE_W-1:0]   ev_type,
  input  logic [erdf_pkg::CODE_W-1:0]   ev_code,
  input  logic [erdf_pkg::VALUE_W-1:0]  ev_value,
  input  logic [erdf_pkg::SEC_W-1:0]    stamp_seconds,
  input  logic [erdf_pkg::USEC_W-1:0]   stamp_micros,
  output logic                          busy,
  output erdf_pkg::push_t               push_o
);

  localparam int RECIP_TOP = erdf_pkg::RECIP_SHIFT + 10;

  logic [erdf_pkg::WIN_W-1:0]   win_r;
  logic                         busy_r;
  erdf_pkg::dir_t               dir_r;
  logic [erdf_pkg::SEC_W-1:0]   chg_sec_r;
  logic [erdf_pkg::USEC_W-1:0]  chg_us_r;
  erdf_pkg::item_t              item_r;
  logic [erdf_pkg::SEC_W-1:0]   sec_r;
  logic [erdf_pkg::USEC_W-1:0]  us_r;
  logic                         ds_zero_r;
  logic                         ds_plus_r;
  logic                         ds_minus_r;
  logic                         qneg_r;
  logic [10:0]                  qmag_r;

  logic [erdf_pkg::SEC_W:0]     ds;
  logic [erdf_pkg::USEC_W:0]    du;
  logic [erdf_pkg::USEC_W:0]    du_neg;
  logic [erdf_pkg::USEC_W-1:0]  du_mag;
  logic [40:0]                  prod;

  logic [erdf_pkg::WIN_W-1:0]   window;
  logic [12:0]                  q_s;
  logic [12:0]                  base;
  logic [12:0]                  dt;
  logic                         in_win;
  logic                         is_vol;
  logic                         press;
  logic                         release_ev;
  logic                         is_scan;
  erdf_pkg::dir_t               key_dir;
  logic                         reversal;
  logic                         drop;

  // Distance front half: deltas against the stored change time and |du|/1000
  assign ds     = {1'b0, stamp_seconds} - {1'b0, chg_sec_r};
  assign du     = {1'b0, stamp_micros} - {1'b0, chg_us_r};
  assign du_neg = ~du + 21'd1;
  assign du_mag = du[erdf_pkg::USEC_W] ? du_neg[erdf_pkg::USEC_W-1:0]
                                       : du[erdf_pkg::USEC_W-1:0];
  assign prod   = {21'd0, du_mag} * {20'd0, erdf_pkg::RECIP_1000};

  always_comb begin
    if (win_r < erdf_pkg::WINDOW_MIN) begin
      window = erdf_pkg::WINDOW_MIN;
    end else if (win_r > erdf_pkg::WINDOW_MAX) begin
      window = erdf_pkg::WINDOW_MAX;
    end else begin
      window = win_r;
    end
  end

  // Distance back half: seconds step of -1, 0 or +1 plus signed quotient
  assign q_s  = qneg_r ? (~{2'b00, qmag_r} + 13'd1) : {2'b00, qmag_r};
  assign base = ds_plus_r  ? erdf_pkg::MS_PER_SEC :
                ds_minus_r ? (~erdf_pkg::MS_PER_SEC + 13'd1) : 13'd0;
  assign dt   = base + q_s;
  assign in_win = (ds_zero_r | ds_plus_r | ds_minus_r) && !dt[12] &&
                  (dt[11:0] < {3'b000, window});

  assign is_vol = (item_r.ev_type == erdf_pkg::TYPE_KEY) &&
                  ((item_r.ev_code == erdf_pkg::CODE_VOL_UP) ||
                   (item_r.ev_code == erdf_pkg::CODE_VOL_DOWN));
  assign key_dir    = (item_r.ev_code == erdf_pkg::CODE_VOL_UP) ? erdf_pkg::DIR_UP
                                                                : erdf_pkg::DIR_DOWN;
  assign press      = is_vol && (item_r.ev_value == erdf_pkg::VAL_PRESS);
  assign release_ev = is_vol && (item_r.ev_value == erdf_pkg::VAL_RELEASE);
  assign is_scan    = (item_r.ev_type == erdf_pkg::TYPE_MISC) &&
                      (item_r.ev_code == erdf_pkg::CODE_SCAN);
  assign reversal   = (key_dir != dir_r) && (dir_r != erdf_pkg::DIR_NONE);

  always_comb begin
    drop = 1'b0;
    if (press && reversal && in_win) begin
      drop = 1'b1;
    end
    if (release_ev && reversal) begin
      drop = 1'b1;
    end
    if (is_scan) begin
      if ((item_r.ev_value == erdf_pkg::SCAN_UP) && (dir_r == erdf_pkg::DIR_DOWN)) begin
        drop = 1'b1;
      end
      if ((item_r.ev_value == erdf_pkg::SCAN_DOWN) && (dir_r == erdf_pkg::DIR_UP)) begin
        drop = 1'b1;
      end
    end
  end

  assign busy         = busy_r;
  assign push_o.valid = busy_r && !drop;
  assign push_o.item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= erdf_pkg::WINDOW_RESET;
      busy_r    <= 1'b0;
      dir_r     <= erdf_pkg::DIR_NONE;
      chg_sec_r <= '0;
      chg_us_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        win_r <= cfg_debounce_ms;
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (busy_r) begin
        busy_r <= 1'b0;
        // every press moves the change time; a kept one also sets direction
        if (press) begin
          chg_sec_r <= sec_r;
          chg_us_r  <= us_r;
          if (!(reversal && in_win)) begin
            dir_r <= key_dir;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r     <= '{ev_type: ev_type, ev_code: ev_code, ev_value: ev_value};
      sec_r      <= stamp_seconds;
      us_r       <= stamp_micros;
      ds_zero_r  <= (ds == '0);
      ds_plus_r  <= (ds == {{erdf_pkg::SEC_W{1'b0}}, 1'b1});
      ds_minus_r <= (ds == '1);
      qneg_r     <= du[erdf_pkg::USEC_W];
      qmag_r     <= prod[RECIP_TOP:erdf_pkg::RECIP_SHIFT];
    end
  end

endmodule

/* rtl/erdf_queue.sv */
`timescale 1ns / 1ps

module erdf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  erdf_pkg::push_t push_i,
  output logic            full,
  output logic            head_valid,
  output erdf_pkg::item_t head,
  input  logic            deq
);

  erdf_pkg::item_t entry_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic [1:0]      count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_i.valid && !deq) begin
      count_nxt = count_r + 2'd1;
    end else if (!push_i.valid && deq) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push_i.valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (deq) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.valid) begin
      entry_r[wr_ptr_r] <= push_i.item;
    end
  end

endmodule

/* rtl/erdf_back.sv */
`timescale 1ns / 1ps

module erdf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  erdf_pkg::item_t               head,
  output logic                          deq,
  input  logic                          pop,
  output logic                          empty,
  output logic [erdf_pkg::TYPE_W-1:0]   out_type,
  output logic [erdf_pkg::CODE_W-1:0]   out_code,
  output logic [erdf_pkg::VALUE_W-1:0]  out_value,
  output logic                          out_last_of_run
);

  logic            valid_r;
  logic            sync_pend_r;
  erdf_pkg::item_t res_r;
  logic            last_r;
  logic            take;

  assign take  = !valid_r || pop;
  assign deq   = take && !sync_pend_r && head_valid;
  assign empty = !valid_r;

  assign out_type        = res_r.ev_type;
  assign out_code        = res_r.ev_code;
  assign out_value       = res_r.ev_value;
  assign out_last_of_run = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      sync_pend_r <= 1'b0;
    end else if (take) begin
      if (sync_pend_r) begin
        valid_r     <= 1'b1;
        sync_pend_r <= 1'b0;
      end else if (head_valid) begin
        valid_r     <= 1'b1;
        sync_pend_r <= (head.ev_type != erdf_pkg::TYPE_SYNC);
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (sync_pend_r) begin
        res_r  <= '{ev_type: erdf_pkg::TYPE_SYNC, ev_code: '0, ev_value: '0};
        last_r <= 1'b1;
      end else begin
        res_r  <= head;
        last_r <= (head.ev_type == erdf_pkg::TYPE_SYNC);
      end
    end
  end

endmodule

/* rtl/encoder_reversal_debounce_filter.sv */
`timescale 1ns / 1ps
// The front takes no new item while deciding one; its distance check has two steps
//   (delta and 1/1000 multiply, then window compare and state update).
// Results leave at one per cycle while popped; a passed non-sync item gives two of them.
// Reset: synchronous, active low; window back to 100 ms, no direction, change time zero.
module encoder_reversal_debounce_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [erdf_pkg::WIN_W-1:0]    cfg_debounce_ms,
  input  logic                          push,
  output logic                          full,
  input  logic [erdf_pkg::TYPE_W-1:0]   in_event_type,
  input  logic [erdf_pkg::CODE_W-1:0]   in_event_code,
  input  logic [erdf_pkg::VALUE_W-1:0]  in_event_value,
  input  logic [erdf_pkg::SEC_W-1:0]    in_stamp_seconds,
  input  logic [erdf_pkg::USEC_W-1:0]   in_stamp_micros,
  output logic                          empty,
  input  logic                          pop,
  output logic [erdf_pkg::TYPE_W-1:0]   out_type,
  output logic [erdf_pkg::CODE_W-1:0]   out_code,
  output logic [erdf_pkg::VALUE_W-1:0]  out_value,
  output logic                          out_last_of_run
);

  logic            accept;
  logic            front_busy;
  logic            q_full;
  logic            q_head_valid;
  logic            q_deq;
  erdf_pkg::push_t q_push;
  erdf_pkg::item_t q_head;

  // Hold new items while the front still decides one, or while the queue
  // has no room for what the front could hand over next.
  assign full   = front_busy || q_full;
  assign accept = push && !full;

  // Front: classify each item against direction and change time, drop or pass.
  erdf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_debounce_ms (cfg_debounce_ms),
    .accept          (accept),
    .ev_type         (in_event_type),
    .ev_code         (in_event_code),
    .ev_value        (in_event_value),
    .stamp_seconds   (in_stamp_seconds),
    .stamp_micros    (in_stamp_micros),
    .busy            (front_busy),
    .push_o          (q_push)
  );

  // Two-entry queue decouples the decision from result delivery.
  erdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (q_push),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .deq        (q_deq)
  );

  // Back: emit each passed item, then a trailing sync unless it is a sync.
  erdf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head            (q_head),
    .deq             (q_deq),
    .pop             (pop),
    .empty           (empty),
    .out_type        (out_type),
    .out_code        (out_code),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run)
  );

  // The front never hands over an item when the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> !q_full)
    else $error("queue overflow");

  // An accepted item keeps the front busy for its decide cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> full)
    else $error("front took an item while deciding");

  // A taken result that is not last of its run is followed by its sync.
  a_sync_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last_of_run) |=>
      (!empty && out_last_of_run && (out_type == erdf_pkg::TYPE_SYNC)))
    else $error("missing trailing sync");

  // Only a passed item that the front just decided may enter the queue.
  a_push_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> front_busy)
    else $error("queue push without a decision");

endmodule
